// File: design/qph_pkg.sv
// qph_pkg: shared types and constants of the quadtree point histogram
// controller/datapath command and status structs, command codes, register indexes
// no dependencies
`timescale 1ns / 1ps

package qph_pkg;

  // command field codes
  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_X_LOW  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_X_HIGH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_Y_LOW  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_Y_HIGH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LEVELS = 3'd4;

  localparam int LEVELS_W = 4;
  localparam logic [LEVELS_W-1:0] LEVELS_RESET = 4'd8;
  localparam int INDEX_W = 17;

  // controller to datapath
  typedef struct packed {
    logic clr_step;   // zero one store entry, advance the clear counter
    logic add_load;   // capture point and bounds, start at the root
    logic add_step;   // read current cell, bisect, advance the index
    logic rd_load;    // capture the read index
    logic rd_issue;   // read the captured cell
    logic out_load;   // move read data into the result register
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;   // clear counter at the last entry
    logic rem_zero;   // no more levels after this step
    logic out_free;   // result register empty or emptying this cycle
  } dp_status_t;

endpackage

// File: design/quadtree_point_histogram.sv
// quadtree_point_histogram: top level, joins the controller and the datapath
// depends on qph_pkg, qph_ctrl, qph_dp, qph_ram
`timescale 1ns / 1ps

// Quadtree point histogram. An add request (command 0) drops one signed
// fixed-point point into a tree of counters over the configured area: the
// root counter is incremented, then the area is bisected once per level in
// use (points on the midpoint go to the low half) and the counter of the cell
// reached at each level is incremented. A read request (command 1) returns
// the counter at an implicit-tree index (root 0, four children per node,
// level by level); an index beyond the store returns 0 with index_error set.
// Adds return nothing. After reset the block zeroes all (4^(MAX_LEVELS+1)-1)/3
// entries of its count store (87381 at the default), one entry per cycle;
// in_ready stays low meanwhile, configuration writes are taken.
// One request is handled at a time. An add walks levels_in_use levels, capped
// at MAX_LEVELS: the count store does one read-modify-write per counter,
// overlapping the read of one cell with the write of the one before, and the
// last write is drained in a final state. A read waits while an earlier
// result is still not taken. Configuration must be written only while the
// block is idle; the block itself does not enforce this.
module quadtree_point_histogram #(
  parameter int MAX_LEVELS  = 8,
  parameter int COUNT_WIDTH = 32,
  parameter int COORD_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // request channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_command,
  input  logic signed [COORD_WIDTH-1:0]     in_point_x,
  input  logic signed [COORD_WIDTH-1:0]     in_point_y,
  input  logic [qph_pkg::INDEX_W-1:0]       in_cell_index,
  // result channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [COUNT_WIDTH-1:0]            out_cell_count,
  output logic                              out_index_error,
  // configuration write port
  input  logic                              cfg_write_en,
  input  logic [qph_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [COORD_WIDTH-1:0]            cfg_data
);
  import qph_pkg::*;

  // counters in a full tree of MAX_LEVELS levels below the root
  localparam int DEPTH  = (4 ** (MAX_LEVELS + 1) - 1) / 3;
  localparam int ADDR_W = $clog2(DEPTH);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // sequencing: clear pass, add walk, read
  qph_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_command(in_command),
    .in_ready  (in_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // bisection, cell index, count store and result register
  qph_dp #(
    .MAX_LEVELS (MAX_LEVELS),
    .COUNT_WIDTH(COUNT_WIDTH),
    .COORD_WIDTH(COORD_WIDTH),
    .DEPTH      (DEPTH),
    .ADDR_W     (ADDR_W)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .in_point_x     (in_point_x),
    .in_point_y     (in_point_y),
    .in_cell_index  (in_cell_index),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_cell_count (out_cell_count),
    .out_index_error(out_index_error),
    .cfg_write_en   (cfg_write_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

endmodule

// File: design/qph_ram.sv
// qph_ram: generic single-write, single-read memory with registered read data
// no dependencies
`timescale 1ns / 1ps

module qph_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  parameter int ADDR_W = 10
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: design/qph_ctrl.sv
// qph_ctrl: sequencing state machine of the quadtree point histogram
// depends on qph_pkg
`timescale 1ns / 1ps

module qph_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_command,
  output logic                in_ready,
  input  qph_pkg::dp_status_t status,
  output qph_pkg::ctrl_cmd_t  cmd
);
  import qph_pkg::*;

  localparam logic [2:0] ST_CLEAR    = 3'd0;
  localparam logic [2:0] ST_IDLE     = 3'd1;
  localparam logic [2:0] ST_ADD      = 3'd2;
  localparam logic [2:0] ST_ADD_LAST = 3'd3;
  localparam logic [2:0] ST_RD_WAIT  = 3'd4;
  localparam logic [2:0] ST_RD_DATA  = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       accept;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (status.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (in_command == CMD_ADD) begin
            cmd.add_load = 1'b1;
            state_nxt    = ST_ADD;
          end else begin
            cmd.rd_load = 1'b1;
            state_nxt   = ST_RD_WAIT;
          end
        end
      end
      ST_ADD: begin
        cmd.add_step = 1'b1;
        if (status.rem_zero) begin
          state_nxt = ST_ADD_LAST;
        end
      end
      ST_ADD_LAST: begin
        // last pending increment is written here
        state_nxt = ST_IDLE;
      end
      ST_RD_WAIT: begin
        if (status.out_free) begin
          cmd.rd_issue = 1'b1;
          state_nxt    = ST_RD_DATA;
        end
      end
      ST_RD_DATA: begin
        cmd.out_load = 1'b1;
        state_nxt    = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: design/qph_dp.sv
// qph_dp: datapath of the quadtree point histogram
// config registers, bisection unit, cell index, count store access, result register
// depends on qph_pkg and qph_ram
`timescale 1ns / 1ps

module qph_dp #(
  parameter int MAX_LEVELS  = 8,
  parameter int COUNT_WIDTH = 32,
  parameter int COORD_WIDTH = 32,
  parameter int DEPTH       = 87381,
  parameter int ADDR_W      = 17
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  qph_pkg::ctrl_cmd_t                  cmd,
  output qph_pkg::dp_status_t                 status,
  input  logic signed [COORD_WIDTH-1:0]       in_point_x,
  input  logic signed [COORD_WIDTH-1:0]       in_point_y,
  input  logic [qph_pkg::INDEX_W-1:0]         in_cell_index,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [COUNT_WIDTH-1:0]              out_cell_count,
  output logic                                out_index_error,
  input  logic                                cfg_write_en,
  input  logic [qph_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [COORD_WIDTH-1:0]              cfg_data
);
  import qph_pkg::*;

  // configuration
  logic signed [COORD_WIDTH-1:0] x_low_r, x_high_r, y_low_r, y_high_r;
  logic [LEVELS_W-1:0]           levels_r, levels_sat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_low_r  <= '0;
      x_high_r <= '0;
      y_low_r  <= '0;
      y_high_r <= '0;
      levels_r <= LEVELS_RESET;
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_X_LOW:  x_low_r  <= cfg_data;
        REG_X_HIGH: x_high_r <= cfg_data;
        REG_Y_LOW:  y_low_r  <= cfg_data;
        REG_Y_HIGH: y_high_r <= cfg_data;
        REG_LEVELS: levels_r <= cfg_data[LEVELS_W-1:0];
        default: ;
      endcase
    end
  end

  assign levels_sat = (levels_r > LEVELS_W'(MAX_LEVELS)) ? LEVELS_W'(MAX_LEVELS) : levels_r;

  // working bounds and point of the add in progress
  logic signed [COORD_WIDTH-1:0] px_r, py_r;
  logic signed [COORD_WIDTH-1:0] xl_r, xh_r, yl_r, yh_r;
  logic signed [COORD_WIDTH:0]   sum_x, sum_y;
  logic signed [COORD_WIDTH-1:0] mid_x, mid_y;
  logic                          x_low, y_low;
  logic [2:0]                    quad;
  logic [ADDR_W-1:0]             idx_r, prev_idx_r;
  logic [LEVELS_W-1:0]           rem_r;
  logic                          wr_pend_r;

  // midpoint is the floor of the half sum
  assign sum_x = {xl_r[COORD_WIDTH-1], xl_r} + {xh_r[COORD_WIDTH-1], xh_r};
  assign sum_y = {yl_r[COORD_WIDTH-1], yl_r} + {yh_r[COORD_WIDTH-1], yh_r};
  assign mid_x = sum_x[COORD_WIDTH:1];
  assign mid_y = sum_y[COORD_WIDTH:1];
  assign x_low = (px_r <= mid_x);
  assign y_low = (py_r <= mid_y);
  assign quad  = (x_low ? 3'd1 : 3'd2) + (y_low ? 3'd0 : 3'd2);

  always_ff @(posedge clk) begin
    if (cmd.add_load) begin
      px_r  <= in_point_x;
      py_r  <= in_point_y;
      xl_r  <= x_low_r;
      xh_r  <= x_high_r;
      yl_r  <= y_low_r;
      yh_r  <= y_high_r;
      idx_r <= '0;
      rem_r <= levels_sat;
    end else if (cmd.add_step) begin
      if (x_low) begin
        xh_r <= mid_x;
      end else begin
        xl_r <= mid_x;
      end
      if (y_low) begin
        yh_r <= mid_y;
      end else begin
        yl_r <= mid_y;
      end
      idx_r      <= (idx_r << 2) + ADDR_W'(quad);
      prev_idx_r <= idx_r;
      rem_r      <= rem_r - 1'b1;
    end
  end

  // increment of the cell read in the previous cycle is pending
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_pend_r <= 1'b0;
    end else begin
      wr_pend_r <= cmd.add_step;
    end
  end

  // clearing pass
  logic [ADDR_W-1:0] clr_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_step) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  // read request
  logic [31:0]       ci_ext;
  logic [ADDR_W-1:0] rd_idx_r;
  logic              rd_err_r;

  assign ci_ext = 32'(in_cell_index);

  always_ff @(posedge clk) begin
    if (cmd.rd_load) begin
      rd_idx_r <= ci_ext[ADDR_W-1:0];
      rd_err_r <= (ci_ext >= 32'(DEPTH));
    end
  end

  // count store
  logic                   ram_wr_en, ram_rd_en;
  logic [ADDR_W-1:0]      ram_wr_addr, ram_rd_addr;
  logic [COUNT_WIDTH-1:0] ram_wr_data, ram_rd_data;

  always_comb begin
    if (cmd.clr_step) begin
      ram_wr_en   = 1'b1;
      ram_wr_addr = clr_cnt_r;
      ram_wr_data = '0;
    end else begin
      ram_wr_en   = wr_pend_r;
      ram_wr_addr = prev_idx_r;
      ram_wr_data = ram_rd_data + 1'b1;
    end
  end

  assign ram_rd_en   = cmd.add_step || cmd.rd_issue;
  assign ram_rd_addr = cmd.add_step ? idx_r : rd_idx_r;

  qph_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (DEPTH),
    .ADDR_W(ADDR_W)
  ) u_counts (
    .clk    (clk),
    .wr_en  (ram_wr_en),
    .wr_addr(ram_wr_addr),
    .wr_data(ram_wr_data),
    .rd_en  (ram_rd_en),
    .rd_addr(ram_rd_addr),
    .rd_data(ram_rd_data)
  );

  // result register
  logic                   out_valid_r;
  logic [COUNT_WIDTH-1:0] out_count_r;
  logic                   out_err_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_count_r <= rd_err_r ? '0 : ram_rd_data;
      out_err_r   <= rd_err_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_cell_count  = out_count_r;
  assign out_index_error = out_err_r;

  assign status.clr_last = (clr_cnt_r == ADDR_W'(DEPTH - 1));
  assign status.rem_zero = (rem_r == '0);
  assign status.out_free = !out_valid_r || out_ready;

endmodule
